@@ sv/lsac_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsac_pkg
// Shared types and codes of the set-associative cache hit/miss counter.
// ----------------------------------------------------------------------------
package lsac_pkg;

    // Access kinds; bit 1 marks a modify (load followed by store).
    localparam logic [1:0] OP_LOAD       = 2'd0;
    localparam logic [1:0] OP_STORE      = 2'd1;
    localparam logic [1:0] OP_MODIFY     = 2'd2;
    localparam int         OP_MODIFY_BIT = 1;

    // Result of the first access of a word.
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_COLD  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_WAYS       = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

    localparam int         IN_ADDR_W = 48;
    localparam logic [2:0] AGE_MAX   = 3'd7;

    typedef struct packed {
        logic [1:0]           op;
        logic [IN_ADDR_W-1:0] address;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        second_hit;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] eviction_count;
    } t_out_word;

endpackage : lsac_pkg
`default_nettype wire

@@ sv/lru_set_assoc_cache_sim.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_sim
// Tag-only set-associative cache model with LRU replacement that counts hits,
// misses and evictions for a stream of load, store and modify accesses.
// ----------------------------------------------------------------------------
// Each input word carries an access kind and a byte address. The address is
// split into block offset, set index and tag by the configured bit counts, and
// the tag is looked up among the ways in use of that set. A hit makes the line
// the most recently used one; a miss fills the lowest free way, or, when the
// set is full, replaces the least recently used way and counts as a miss and
// an eviction. A modify adds one more hit for its store part. Every access
// returns one output word with its outcome and the three running totals,
// which saturate at all ones. Each set lives in one row of a single-port
// synchronous memory holding the valid bits, ages and tags of all its ways.
// The edge that accepts the word issues the row read, and in the following
// cycle the row is compared, updated and written back while the output
// word is loaded. The next word is accepted in the cycle after that, so
// back-to-back accesses to one set always see the updated row. No new word
// is accepted before the last is written back; a held output word stretches
// the update cycle until the output register frees. A flip-flop per set
// marks whether its row was ever written; reset clears these at once, so
// there is no clearing pass after reset. Configuration is to be written over
// the APB port only while no access is in flight; not enforced by the block.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_sim
    import lsac_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 48
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // access words in
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    // result words out
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_word  o_out_word,
    // configuration
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire  [3:0] paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W    = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
    localparam logic [3:0] SET_CLAMP = 4'(MAX_SET_BITS);
    localparam logic [4:0] WAY_CLAMP = 5'(MAX_WAYS);

    typedef struct packed {
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0][2:0]       age;
        logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
    } t_row;

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

    function automatic logic [2:0] age_inc(input logic [2:0] a);
        return (a == AGE_MAX) ? a : a + 3'd1;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] c, input logic [1:0] d);
        logic [32:0] s;
        s = {1'b0, c} + {31'd0, d};
        return s[32] ? '1 : s[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0] r_set_bits;
    logic [3:0] r_ways;
    logic [4:0] r_block_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= 3'd4;
            r_ways       <= 4'd1;
            r_block_bits <= 5'd4;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_SET_BITS:   r_set_bits   <= pwdata[2:0];
                REG_WAYS:       r_ways       <= pwdata[3:0];
                REG_BLOCK_BITS: r_block_bits <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_SET_BITS:   prdata = {29'd0, r_set_bits};
            REG_WAYS:       prdata = {28'd0, r_ways};
            REG_BLOCK_BITS: prdata = {27'd0, r_block_bits};
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // Address split at accept
    // ------------------------------------------------------------------
    logic [3:0]          set_eff;
    logic [4:0]          ways_eff;
    logic [TAG_W-1:0]    addr_m;
    logic [TAG_W-1:0]    addr_sh;
    logic [5:0]          tag_sh;
    logic [SET_W-1:0]    set_mask;
    logic [SET_W-1:0]    in_set;
    logic [TAG_W-1:0]    in_tag;
    logic [MAX_WAYS-1:0] in_use;
    logic                in_take;

    always_comb begin
        set_eff  = ({1'b0, r_set_bits} > SET_CLAMP) ? SET_CLAMP : {1'b0, r_set_bits};
        ways_eff = (r_ways == 4'd0) ? 5'd1 : {1'b0, r_ways};
        if (ways_eff > WAY_CLAMP) begin
            ways_eff = WAY_CLAMP;
        end
        addr_m  = i_in_word.address[TAG_W-1:0];
        addr_sh = addr_m >> r_block_bits;
        tag_sh  = {1'b0, r_block_bits} + {2'd0, set_eff};
        in_tag  = addr_m >> tag_sh;
        for (int i = 0; i < SET_W; i++) begin
            set_mask[i] = (i < MAX_SET_BITS) && (4'(i) < set_eff);
        end
        in_set = addr_sh[SET_W-1:0] & set_mask;
        for (int k = 0; k < MAX_WAYS; k++) begin
            in_use[k] = 5'(k) < ways_eff;
        end
    end

    // ------------------------------------------------------------------
    // Set memory and per-set written flags
    // ------------------------------------------------------------------
    t_row                r_mem [NUM_SETS];
    t_row                r_rd_data;
    logic [NUM_SETS-1:0] r_row_valid;
    logic                r_rd_rowv;
    logic                wr_en;
    t_row                n_row;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rd_data <= r_mem[in_set];
        end
        if (wr_en) begin
            r_mem[r_set] <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Control and counters
    // ------------------------------------------------------------------
    t_state              r_state;
    logic [SET_W-1:0]    r_set;
    logic [TAG_W-1:0]    r_tag;
    logic [MAX_WAYS-1:0] r_use;
    logic                r_mod;
    logic [31:0]         r_hits;
    logic [31:0]         r_misses;
    logic [31:0]         r_evicts;

    t_row             rd;
    logic             hit_any;
    logic [WAY_W-1:0] hit_way;
    logic             free_any;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] victim;
    logic [2:0]       vmax;
    logic [2:0]       hit_age;
    logic [1:0]       outcome;
    logic [1:0]       hit_inc;
    logic             out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !(o_out_valid && i_out_stall);
    assign wr_en      = (r_state == S_LOOK) && out_free;

    always_comb begin
        rd       = r_rd_rowv ? r_rd_data : '0;
        n_row    = rd;
        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        // Descending scans so the lowest-numbered way wins.
        for (int k = MAX_WAYS - 1; k >= 0; k--) begin
            if (r_use[k] && rd.valid[k] && (rd.tag[k] == r_tag)) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(k);
            end
            if (r_use[k] && !rd.valid[k]) begin
                free_any = 1'b1;
                free_way = WAY_W'(k);
            end
        end
        // Oldest way; ties go to the lowest index.
        victim = '0;
        vmax   = rd.age[0];
        for (int k = 1; k < MAX_WAYS; k++) begin
            if (r_use[k] && (rd.age[k] > vmax)) begin
                victim = WAY_W'(k);
                vmax   = rd.age[k];
            end
        end
        hit_age = rd.age[hit_way];

        priority if (hit_any) begin
            outcome = OUT_HIT;
            for (int k = 0; k < MAX_WAYS; k++) begin
                if (r_use[k] && (WAY_W'(k) != hit_way) && rd.valid[k] &&
                    (rd.age[k] < hit_age)) begin
                    n_row.age[k] = age_inc(rd.age[k]);
                end
            end
            n_row.age[hit_way] = 3'd0;
        end else if (free_any) begin
            outcome = OUT_COLD;
            for (int k = 0; k < MAX_WAYS; k++) begin
                if (r_use[k] && rd.valid[k]) begin
                    n_row.age[k] = age_inc(rd.age[k]);
                end
            end
            n_row.valid[free_way] = 1'b1;
            n_row.tag[free_way]   = r_tag;
            n_row.age[free_way]   = 3'd0;
        end else begin
            outcome = OUT_EVICT;
            for (int k = 0; k < MAX_WAYS; k++) begin
                if (r_use[k] && (WAY_W'(k) != victim)) begin
                    n_row.age[k] = age_inc(rd.age[k]);
                end
            end
            n_row.tag[victim] = r_tag;
            n_row.age[victim] = 3'd0;
        end

        // The store half of a modify always hits the line just touched.
        hit_inc = {1'b0, hit_any} + {1'b0, r_mod};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_valid <= '0;
            r_rd_rowv   <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // A word taken this cycle frees the output unless a new one loads.
            if (o_out_valid && !i_out_stall && !wr_en) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_set     <= in_set;
                        r_tag     <= in_tag;
                        r_use     <= in_use;
                        r_mod     <= i_in_word.op[OP_MODIFY_BIT];
                        r_rd_rowv <= r_row_valid[in_set];
                        r_state   <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (out_free) begin
                        r_row_valid[r_set] <= 1'b1;
                        r_hits   <= sat_add(r_hits, hit_inc);
                        r_misses <= sat_add(r_misses, {1'b0, !hit_any});
                        r_evicts <= sat_add(r_evicts, {1'b0, !hit_any && !free_any});
                        o_out_word.outcome        <= outcome;
                        o_out_word.second_hit     <= r_mod;
                        o_out_word.hit_count      <= sat_add(r_hits, hit_inc);
                        o_out_word.miss_count     <= sat_add(r_misses, {1'b0, !hit_any});
                        o_out_word.eviction_count <= sat_add(r_evicts,
                                                             {1'b0, !hit_any && !free_any});
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule : lru_set_assoc_cache_sim
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the LRU set-associative cache hit/miss counter.
// An access-level model in this file keeps its own valid bits, tags and ages
// and predicts the word returned for every accepted access. The
// monitor compares each returned word field by field. Directed tests cover
// the reset geometry, LRU replacement and out-of-range register values.
// Randomized traffic over many geometries follows, with idle bursts on both
// sides.
// ----------------------------------------------------------------------------
module tb;
    import lsac_pkg::*;

    // Geometry of the instance (the block's default parameters).
    localparam int MODEL_SET_BITS = 6;
    localparam int MODEL_SETS     = 1 << MODEL_SET_BITS;
    localparam int MODEL_WAYS     = 8;
    localparam int ADDR_W         = 48;

    // Cycles with no handshake of any kind before the run is declared hung.
    localparam int HANG_LIMIT = 2000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_word           i_in_word   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_word          o_out_word;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [3:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;

    lru_set_assoc_cache_sim uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cache model: tag store, LRU ages, running totals and a mirror of
    // the three geometry registers as the block holds them.
    // ------------------------------------------------------------------
    logic              line_v [MODEL_SETS][MODEL_WAYS];
    logic [ADDR_W-1:0] line_t [MODEL_SETS][MODEL_WAYS];
    logic [2:0]        line_a [MODEL_SETS][MODEL_WAYS];
    logic [31:0]       hit_total;
    logic [31:0]       miss_total;
    logic [31:0]       evict_total;

    logic [2:0]        cfg_set_bits   = 3'd4;
    logic [3:0]        cfg_ways       = 4'd1;
    logic [4:0]        cfg_block_bits = 5'd4;

    // Result words predicted for accepted accesses, oldest first.
    t_out_word         expected_results [$];

    int                errors  = 0;
    bit                idle_on = 1'b1;
    int                stall_left = 0;
    int                quiet_cycles = 0;

    // Ages count up to the oldest value and stay there.
    function automatic logic [2:0] age_up(input logic [2:0] a);
        return (a < AGE_MAX) ? a + 3'd1 : AGE_MAX;
    endfunction

    // A set_index_bits value above the instance's maximum acts as the maximum.
    function automatic int eff_set_bits();
        return (int'(cfg_set_bits) > MODEL_SET_BITS) ? MODEL_SET_BITS : int'(cfg_set_bits);
    endfunction

    // A way count of zero acts as one, anything above the maximum as the maximum.
    function automatic int eff_ways();
        if (cfg_ways == 4'd0)
            return 1;
        return (int'(cfg_ways) > MODEL_WAYS) ? MODEL_WAYS : int'(cfg_ways);
    endfunction

    // One lookup in one set: a hit refreshes the line, a miss fills the lowest
    // free way, and a miss on a full set replaces the oldest way (lowest index
    // among equal ages).
    function automatic logic [1:0] touch_line(input int set, input logic [ADDR_W-1:0] tg,
                                              input int ways);
        int         w;
        int         k;
        int         free_way;
        int         victim;
        logic [2:0] a;
        for (w = 0; w < ways; w++) begin
            if (line_v[set][w] && line_t[set][w] == tg) begin
                a = line_a[set][w];
                for (k = 0; k < ways; k++)
                    if (k != w && line_v[set][k] && line_a[set][k] < a)
                        line_a[set][k] = age_up(line_a[set][k]);
                line_a[set][w] = 3'd0;
                if (hit_total != '1)
                    hit_total++;
                return OUT_HIT;
            end
        end
        if (miss_total != '1)
            miss_total++;
        free_way = ways;
        for (w = ways - 1; w >= 0; w--)
            if (!line_v[set][w])
                free_way = w;
        if (free_way < ways) begin
            for (w = 0; w < ways; w++)
                if (line_v[set][w])
                    line_a[set][w] = age_up(line_a[set][w]);
            line_v[set][free_way] = 1'b1;
            line_t[set][free_way] = tg;
            line_a[set][free_way] = 3'd0;
            return OUT_COLD;
        end
        victim = 0;
        for (w = 1; w < ways; w++)
            if (line_a[set][w] > line_a[set][victim])
                victim = w;
        for (w = 0; w < ways; w++)
            if (w != victim)
                line_a[set][w] = age_up(line_a[set][w]);
        line_t[set][victim] = tg;
        line_a[set][victim] = 3'd0;
        if (evict_total != '1)
            evict_total++;
        return OUT_EVICT;
    endfunction

    // Splits the address with the current geometry and runs the access; a
    // modify (bit 1 of the op) does a second lookup for its store part.
    function automatic t_out_word predict_access(input t_in_word w);
        t_out_word         r;
        int                s;
        int                b;
        int                set;
        logic [ADDR_W-1:0] tg;
        s   = eff_set_bits();
        b   = int'(cfg_block_bits);
        set = int'((w.address >> b) & ((48'd1 << s) - 48'd1));
        tg  = w.address >> (b + s);
        r.outcome    = touch_line(set, tg, eff_ways());
        r.second_hit = w.op[OP_MODIFY_BIT];
        if (r.second_hit)
            void'(touch_line(set, tg, eff_ways()));
        r.hit_count      = hit_total;
        r.miss_count     = miss_total;
        r.eviction_count = evict_total;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving side.
    // ------------------------------------------------------------------

    // Sends one access word. The valid line is only lowered when an idle
    // burst is taken, so back-to-back words keep it high across the edge.
    // The prediction is made at the edge that accepts the word.
    task automatic send_access(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
        t_in_word w;
        w.op      = op;
        w.address = addr;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        expected_results.push_back(predict_access(w));
    endtask

    // Ends a phase: no further words, and every predicted result returned.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready. psel is
    // left high so that the next write can follow directly.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
    endtask

    // Writes all three geometry registers. Only called with nothing in flight.
    task automatic program_geometry(input logic [2:0] set_bits, input logic [3:0] ways,
                                    input logic [4:0] block_bits);
        apb_write(REG_SET_BITS, {29'd0, set_bits});
        cfg_set_bits = set_bits;
        apb_write(REG_WAYS, {28'd0, ways});
        cfg_ways = ways;
        apb_write(REG_BLOCK_BITS, {27'd0, block_bits});
        cfg_block_bits = block_bits;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly addresses built from a small pool of tags and sets under the
    // current geometry, so lines get reused and replaced; a quarter are fully
    // random so every address bit toggles.
    function automatic logic [ADDR_W-1:0] random_address();
        int                s;
        int                b;
        logic [ADDR_W-1:0] tg;
        logic [ADDR_W-1:0] st;
        logic [ADDR_W-1:0] off;
        s = eff_set_bits();
        b = int'(cfg_block_bits);
        if ($urandom_range(0, 3) == 0)
            return ADDR_W'({$urandom, $urandom});
        tg  = ADDR_W'($urandom_range(0, eff_ways() + 1));
        st  = ADDR_W'($urandom_range(0, 3)) & ((48'd1 << s) - 48'd1);
        off = ADDR_W'({$urandom, $urandom}) & ((48'd1 << b) - 48'd1);
        return (tg << (b + s)) | (st << b) | off;
    endfunction

    // ------------------------------------------------------------------
    // Receiving side: random stall bursts while idling is enabled.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
        i_out_stall <= (stall_left > 0);
    end

    // Compares each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result word with no access waiting: %h", o_out_word);
                errors++;
            end else begin
                exp_w = expected_results.pop_front();
                if (o_out_word.outcome !== exp_w.outcome) begin
                    $error("outcome: expected %0d, got %0d", exp_w.outcome,
                           o_out_word.outcome);
                    errors++;
                end
                if (o_out_word.second_hit !== exp_w.second_hit) begin
                    $error("second_hit: expected %0d, got %0d", exp_w.second_hit,
                           o_out_word.second_hit);
                    errors++;
                end
                if (o_out_word.hit_count !== exp_w.hit_count) begin
                    $error("hit_count: expected %0d, got %0d", exp_w.hit_count,
                           o_out_word.hit_count);
                    errors++;
                end
                if (o_out_word.miss_count !== exp_w.miss_count) begin
                    $error("miss_count: expected %0d, got %0d", exp_w.miss_count,
                           o_out_word.miss_count);
                    errors++;
                end
                if (o_out_word.eviction_count !== exp_w.eviction_count) begin
                    $error("eviction_count: expected %0d, got %0d", exp_w.eviction_count,
                           o_out_word.eviction_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any accepted word or completed register write counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset geometry: 16 sets, one way, 16-byte blocks. Hits within a block,
    // conflicts in one set, op three acting as a modify, all-ones address.
    task automatic test_reset_geometry();
        send_access(OP_LOAD,  48'h0000_0000_0000);
        send_access(OP_LOAD,  48'h0000_0000_0008);
        send_access(OP_STORE, 48'h0000_0000_0100);
        send_access(OP_MODIFY, 48'h0000_0000_0000);
        send_access(OP_MODIFY | OP_STORE, 48'hFFFF_FFFF_FFFF);
        send_access(OP_LOAD,  48'hFFFF_FFFF_FFFF);
        wait_for_results();
    endtask

    // One fully associative set of eight byte-sized lines: fill every way,
    // refresh the oldest, then force replacements of the least recently used.
    task automatic test_lru_replacement();
        int i;
        program_geometry(3'd0, 4'd8, 5'd0);
        for (i = 1; i <= 8; i++)
            send_access(OP_LOAD, ADDR_W'(i));
        send_access(OP_LOAD, 48'd1);
        send_access(OP_STORE, 48'd9);
        send_access(OP_MODIFY, 48'd2);
        wait_for_results();
    endtask

    // Register values outside the legal range: set bits above the maximum,
    // zero and oversized way counts, and block offsets up to 31 bits.
    task automatic test_register_clamping();
        program_geometry(3'd7, 4'd0, 5'd31);
        send_access(OP_LOAD,  48'h0000_0000_0000);
        send_access(OP_LOAD,  48'hFFFF_FFFF_FFFF);
        send_access(OP_STORE, 48'h8000_0000_0000);
        wait_for_results();
        program_geometry(3'd7, 4'd15, 5'd16);
        send_access(OP_MODIFY, 48'h1234_5678_9ABC);
        send_access(OP_MODIFY | OP_STORE, 48'h1234_5678_9ABC);
        send_access(OP_LOAD, 48'hFFFF_FFFF_FFFF);
        wait_for_results();
    endtask

    // Random traffic in phases of 100 words. Lines are kept across geometry
    // changes, which exercises stale lines and ways that drop out of use.
    // The first phases take the register extremes; the last two run with no
    // idling on either side.
    task automatic test_random_traffic();
        int         ph;
        int         n;
        logic [2:0] s;
        logic [3:0] wy;
        logic [4:0] bb;
        for (ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin
                    s = 3'd0; wy = 4'd1; bb = 5'd0;
                end
                1: begin
                    s = 3'd6; wy = 4'd8; bb = 5'd16;
                end
                2: begin
                    s = 3'd7; wy = 4'd15; bb = 5'd31;
                end
                3: begin
                    s = 3'd1; wy = 4'd0; bb = 5'd2;
                end
                default: begin
                    s  = 3'($urandom_range(0, 6));
                    wy = 4'($urandom_range(1, 8));
                    bb = 5'($urandom_range(0, 16));
                end
            endcase
            idle_on = (ph < 10) && (ph % 3 != 2);
            program_geometry(s, wy, bb);
            for (n = 0; n < 100; n++)
                send_access(2'($urandom_range(0, 3)), random_address());
            wait_for_results();
        end
    endtask

    initial begin
        int s;
        int w;
        for (s = 0; s < MODEL_SETS; s++)
            for (w = 0; w < MODEL_WAYS; w++) begin
                line_v[s][w] = 1'b0;
                line_t[s][w] = '0;
                line_a[s][w] = 3'd0;
            end
        hit_total   = '0;
        miss_total  = '0;
        evict_total = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_lru_replacement();
        test_register_clamping();
        test_random_traffic();

        // Everything has returned; give a stray extra word time to show up.
        idle_on = 1'b0;
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
